// ===== sv/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and codes of the streaming pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // item kind on the input channel
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  // input item
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // result item
  typedef struct packed {
    logic        found;
    logic [31:0] position;
  } result_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_HOLD
  } state_t;

endpackage

// ===== sv/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kmp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/kmp_string_matcher_core.sv =====
// Items that need no match step: a pattern byte that starts or overflows a pattern, or a
//   text byte after a match or on an empty pattern; other items run one match step plus
//   one more per failure-link step, and a result may wait behind a stalled output.
// No new item is taken while a match step sequence runs or a result waits; each match
//   step waits on the registered read of the pattern/failure memory.
// Result registered from the last step; reset clears control state only.
// ----------------------------------------------------------------------------
// kmp_string_matcher_core
// Streaming first-occurrence search with an on-the-fly built failure table.
// ----------------------------------------------------------------------------
module kmp_string_matcher_core
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int RAM_W = IDX_W + 8;
  localparam int SUM_W = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;

  // control and search registers
  state_t                   state, state_next;
  logic [CNT_W-1:0]         pattern_count;
  logic [CNT_W-1:0]         border_tracker;
  logic                     pattern_closed;
  logic [CNT_W-1:0]         match_length;
  logic [POSITION_BITS-1:0] text_position;
  logic                     search_done;
  logic [CNT_W-1:0]         k;
  logic [7:0]               cur_byte;
  logic                     is_text;
  logic                     is_last;
  result_t                  pend;

  // memory interface
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [RAM_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [RAM_W-1:0] rd_data;
  logic [7:0]       rd_byte;
  logic [IDX_W-1:0] rd_fail;

  // decode
  logic             accept, pat, txt, fresh;
  logic [CNT_W-1:0] j;
  logic             pat_store, pat_search, txt_active, txt_empty, txt_search;
  logic             start_search;
  logic [CNT_W-1:0] start_k;
  logic             hit, fall, done;
  logic [CNT_W-1:0] new_k;
  logic             txt_done, found_now, miss_now;
  logic             res_valid, out_free, res_wait;
  result_t          res;
  logic [SUM_W-1:0] pos_sum;

  assign rd_byte = rd_data[7:0];
  assign rd_fail = rd_data[RAM_W-1:8];

  // input decode
  always_comb begin
    accept       = item_valid && (state == ST_IDLE);
    pat          = accept && (item.mode == MODE_PATTERN);
    txt          = accept && (item.mode == MODE_TEXT);
    fresh        = pattern_closed;
    j            = fresh ? '0 : pattern_count;
    pat_store    = pat && (j < CNT_W'(MAX_PATTERN));
    pat_search   = pat_store && (j != '0);
    txt_active   = txt && !search_done;
    txt_empty    = txt_active && (pattern_count == '0);
    txt_search   = txt_active && (pattern_count != '0);
    start_search = pat_search || txt_search;
    start_k      = pat ? border_tracker : match_length;
  end

  // one match step on the memory read data
  always_comb begin
    hit       = (rd_byte == cur_byte);
    fall      = (state == ST_LOOK) && (k != '0) && !hit;
    done      = (state == ST_LOOK) && !fall;
    new_k     = hit ? k + CNT_W'(1) : k;
    txt_done  = done && is_text;
    found_now = txt_done && (new_k >= pattern_count);
    miss_now  = txt_done && !found_now && is_last;
  end

  // result formation
  always_comb begin
    pos_sum      = SUM_W'(text_position) - SUM_W'(pattern_count) + SUM_W'(1);
    res_valid    = txt_empty || found_now || miss_now;
    res.found    = txt_empty || found_now;
    res.position = txt_empty ? 32'd1 : (found_now ? pos_sum[31:0] : 32'd0);
    out_free     = !result_valid || !result_stall;
    res_wait     = res_valid && !out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_search) begin
          state_next = ST_LOOK;
        end else if (res_wait) begin
          state_next = ST_HOLD;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_next = res_wait ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall = (state != ST_IDLE);
    wr_en      = pat_store;
    wr_addr    = j[IDX_W-1:0];
    wr_data    = {(fresh ? IDX_W'(0) : border_tracker[IDX_W-1:0]), item.data_byte};
    rd_en      = start_search || fall;
    rd_addr    = start_search ? start_k[IDX_W-1:0] : rd_fail;
  end

  // pattern bytes and failure links
  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (RAM_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pattern and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count  <= '0;
      border_tracker <= '0;
      pattern_closed <= 1'b1;
      match_length   <= '0;
      text_position  <= '0;
      search_done    <= 1'b0;
    end else begin
      // pattern byte transfer
      if (pat) begin
        pattern_closed <= item.last;
        pattern_count  <= pat_store ? j + CNT_W'(1) : j;
        if (fresh) begin
          border_tracker <= '0;
          match_length   <= '0;
          text_position  <= '0;
          search_done    <= 1'b0;
        end
      end
      // text byte transfer
      if (txt) begin
        pattern_closed <= 1'b1;
        if (item.last && !txt_search) begin
          match_length  <= '0;
          text_position <= '0;
          search_done   <= 1'b0;
        end else begin
          if (txt_active && (text_position != '1)) begin
            text_position <= text_position + POSITION_BITS'(1);
          end
          if (txt_empty) begin
            search_done <= 1'b1;
          end
        end
      end
      // end of a match step sequence
      if (done) begin
        if (!is_text) begin
          border_tracker <= new_k;
        end else if (is_last) begin
          match_length  <= '0;
          text_position <= '0;
          search_done   <= 1'b0;
        end else begin
          match_length <= new_k;
          if (found_now) begin
            search_done <= 1'b1;
          end
        end
      end
    end
  end

  // working registers of the step sequence
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= item.data_byte;
      is_text  <= (item.mode == MODE_TEXT);
      is_last  <= item.last;
    end
    if (start_search) begin
      k <= start_k;
    end else if (fall) begin
      k <= CNT_W'(rd_fail);
    end
    if (res_wait) begin
      pend <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      if (state == ST_HOLD) begin
        result_valid <= 1'b1;
        result       <= pend;
      end else if (res_valid) begin
        result_valid <= 1'b1;
        result       <= res;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a step only ever reads a stored pattern entry
  a_look_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> (k < pattern_count))
    else $error("match step index beyond stored pattern");

  // the tracked border is a proper border of the stored pattern
  a_border_proper: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (pattern_count != '0)) |-> (border_tracker < pattern_count))
    else $error("border not shorter than pattern");

  // an open search never holds a complete match
  a_match_open: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !search_done) |->
      ((match_length < pattern_count) || (match_length == '0)))
    else $error("partial match length out of range");

  // a pending result only waits behind a full output register
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> result_valid)
    else $error("result held while output register empty");
`endif

endmodule
